>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

>>> hw/rtl/sha_pkg.sv
package sha_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic load_iv;     // load initial value, clear counters
        logic push;        // store c.word into buffer
        t_word word;
        logic add_bytes;   // add c.nbytes to byte count
        logic [2:0] nbytes;
        logic start;       // start compression of the buffer
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic [3:0] pos;
    } t_status;

    function automatic t_word sha_k(input logic [5:0] i);
        t_word k [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic t_word sha_iv(input logic v, input logic [2:0] i);
        t_word iv [16] = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19,
            32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
            32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
        return iv[{v, i}];
    endfunction

    localparam logic [7:0] PAD_MARK = 8'b10000000;

endpackage

>>> hw/rtl/sha_datapath.sv
`include "assert_macros.svh"

module sha_datapath
    import sha_pkg::*;
#(
    parameter int ROUNDS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_variant,
    input  t_cmd       i_cmd,
    input  logic [2:0] i_rd_index,
    output t_word      o_rd_word,
    output logic [63:0] o_bit_len,
    output t_status    o_status
);

    t_word r_h [8];
    t_word r_w [16];     // message schedule window, entry 0 is the current word
    t_word r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h7;
    logic [3:0] r_pos;
    logic [60:0] r_count;
    logic r_busy;
    logic [6:0] r_round;
    logic r_fold;

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    t_word s0, s1, ch, maj, sig0, sig1, t1, t2, w_new;

    always_comb begin
        sig1 = rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25);
        ch = (r_e & r_f) ^ (~r_e & r_g);
        t1 = r_h7 + sig1 + ch + sha_k(r_round[5:0]) + r_w[0];
        sig0 = rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22);
        maj = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
        t2 = sig0 + maj;
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_pos <= '0;
            r_count <= '0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_iv(1'b0, 3'(i));
        end else if (i_cmd.load_iv) begin
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_pos <= '0;
            r_count <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_iv(i_variant, 3'(i));
        end else begin
            if (i_cmd.add_bytes) r_count <= r_count + 61'(i_cmd.nbytes);
            if (i_cmd.push) begin
                r_w[r_pos] <= i_cmd.word;
                r_pos <= r_pos + 4'd1;
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_round <= '0;
                {r_a, r_b, r_c, r_d} <= {r_h[0], r_h[1], r_h[2], r_h[3]};
                {r_e, r_f, r_g, r_h7} <= {r_h[4], r_h[5], r_h[6], r_h[7]};
            end else if (r_fold) begin
                r_fold <= 1'b0;
                r_busy <= 1'b0;
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e; r_h[5] <= r_h[5] + r_f;
                r_h[6] <= r_h[6] + r_g; r_h[7] <= r_h[7] + r_h7;
            end else if (r_busy) begin
                r_h7 <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= w_new;
                r_round <= r_round + 7'd1;
                if (r_round == 7'(ROUNDS - 1)) r_fold <= 1'b1;
            end
        end
    end

    assign o_rd_word = r_h[i_rd_index];
    assign o_bit_len = {r_count, 3'b000};
    assign o_status = '{busy: r_busy, pos: r_pos};

    `ASSERT_CLK(a_no_push_busy, i_clk, i_rst_n, r_busy |-> !i_cmd.push)
    `ASSERT_CLK(a_start_full, i_clk, i_rst_n, i_cmd.start |-> (r_pos == 4'd0 && !r_busy))
    `ASSERT_CLK(a_fold_ends, i_clk, i_rst_n, r_fold && !i_cmd.load_iv |=> !r_busy)

endmodule

>>> hw/rtl/sha_ctrl.sv
`include "assert_macros.svh"

module sha_ctrl
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_word      i_data_word,
    input  logic [2:0] i_valid_bytes,
    input  logic       i_is_last,
    input  logic       i_cfg_valid,
    input  logic       i_variant,
    input  t_status    i_status,
    input  logic [63:0] i_bit_len,
    input  t_word      i_rd_word,
    output logic [2:0] o_rd_index,
    output t_cmd       o_cmd,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_word      o_digest_word,
    output logic [2:0] o_word_index,
    output logic       o_last_word
);

    localparam logic [2:0] S_IN = 3'd0;
    localparam logic [2:0] S_WAIT = 3'd1;   // compression of a full data block
    localparam logic [2:0] S_PAD = 3'd2;    // pushing padding words
    localparam logic [2:0] S_PWAIT = 3'd3;  // compression during padding
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_mark_done, n_mark_done;   // 0x80 word still owed when full word was last
    logic       r_seen_start, n_seen_start;
    logic [2:0] r_idx, n_idx;
    logic       r_ov, n_ov;
    t_word      r_dw;
    logic [2:0] r_wi;
    logic       r_lw;
    logic       in_acc, out_free, final_idx;
    logic [2:0] nb;
    t_word      keep, tail;

    assign o_in_ready = (r_state == S_IN) && !i_status.busy;
    assign in_acc = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;
    assign final_idx = i_variant ? (r_idx == 3'd6) : (r_idx == 3'd7);
    assign o_rd_index = r_idx;

    always_comb begin
        nb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
        keep = (nb == 3'd0) ? 32'h0 : ~(32'hffffffff >> {nb, 3'b000});
        tail = (i_data_word & keep) | (32'(PAD_MARK) << (5'd24 - {nb[1:0], 3'b000}));
    end

    always_comb begin
        n_state = r_state;
        n_mark_done = r_mark_done;
        n_seen_start = 1'b0;
        n_idx = r_idx;
        n_ov = r_ov && !i_out_ready;
        o_cmd = '0;
        unique case (r_state)
            S_IN: begin
                if (in_acc) begin
                    o_cmd.push = 1'b1;
                    o_cmd.add_bytes = 1'b1;
                    if (!i_is_last) begin
                        o_cmd.nbytes = 3'd4;
                        o_cmd.word = i_data_word;
                        if (i_status.pos == 4'd15) n_state = S_WAIT;
                    end else begin
                        o_cmd.nbytes = nb;
                        o_cmd.word = (nb == 3'd4) ? i_data_word : tail;
                        n_mark_done = (nb != 3'd4);
                        if (i_status.pos == 4'd15) n_idx = 3'd1;
                        n_state = S_PAD;
                    end
                end
            end
            S_WAIT: begin
                if (i_status.pos == 4'd0 && !i_status.busy && !r_seen_start) begin
                    o_cmd.start = 1'b1;
                    n_seen_start = 1'b1;
                end
                if (r_seen_start && !i_status.busy) n_state = S_IN;
                else if (r_seen_start) n_seen_start = 1'b1;
            end
            S_PAD: begin
                // r_idx during padding: 0 = filling, 1 = block full, 2 = length high
                // word stored, 3 = final block full.
                if (r_idx == 3'd1 || r_idx == 3'd3) begin
                    o_cmd.start = 1'b1;
                    n_seen_start = 1'b1;
                    n_state = S_PWAIT;
                end else begin
                    o_cmd.push = 1'b1;
                    if (!r_mark_done) begin
                        o_cmd.word = {PAD_MARK, 24'h0};
                        n_mark_done = 1'b1;
                    end else if (i_status.pos == 4'd14) begin
                        // Reaching word 14 after the marker leaves room for the length.
                        o_cmd.word = i_bit_len[63:32];
                        n_idx = 3'd2;
                    end else if (r_idx == 3'd2) begin
                        o_cmd.word = i_bit_len[31:0];
                    end else begin
                        o_cmd.word = '0;
                    end
                    if (i_status.pos == 4'd15) n_idx = (r_idx == 3'd2) ? 3'd3 : 3'd1;
                end
            end
            S_PWAIT: begin
                if (r_seen_start && !i_status.busy) begin
                    if (r_idx == 3'd3) begin
                        n_state = S_OUT;
                        n_idx = 3'd0;
                    end else begin
                        n_state = S_PAD;
                        n_idx = 3'd0;
                    end
                end else begin
                    n_seen_start = 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (final_idx) begin
                        o_cmd.load_iv = 1'b1;
                        n_idx = 3'd0;
                        n_state = S_IN;
                    end
                end
            end
            default: n_state = S_IN;
        endcase
        if (i_cfg_valid) begin
            n_state = S_IN;
            n_idx = 3'd0;
            n_ov = 1'b0;
            o_cmd = '0;
            o_cmd.load_iv = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_mark_done <= 1'b0;
            r_seen_start <= 1'b0;
            r_idx <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mark_done <= n_mark_done;
            r_seen_start <= n_seen_start;
            r_idx <= n_idx;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_dw <= i_rd_word;
            r_wi <= r_idx;
            r_lw <= final_idx;
        end
    end

    assign o_out_valid = r_ov;
    assign o_digest_word = r_dw;
    assign o_word_index = r_wi;
    assign o_last_word = r_lw;

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        r_ov && !i_out_ready && !i_cfg_valid |=> r_ov && $stable(r_dw))
    `ASSERT_CLK(a_no_in_out, i_clk, i_rst_n, r_state == S_OUT |-> !o_in_ready)
    `ASSERT_CLK(a_idx_pad, i_clk, i_rst_n, r_state == S_PAD |-> r_idx <= 3'd3)

endmodule

>>> hw/rtl/sha256_hash_core_top.sv
// SHA-256 / SHA-224 hash core.
// Input channel (i_in_valid / o_in_ready) moves one 32-bit message word,
// big-endian, with a byte count and a last flag. Every 16th word starts a
// compression of 64 rounds at one round per cycle plus setup and fold,
// during which input is held off; so the input rate is set by the
// single shared round unit.
// After a last word the core pushes padding one word per cycle, pausing for one
// or two final compressions, then sends 8 (SHA-256) or 7 (SHA-224) digest
// words on the output channel (o_out_valid / i_out_ready), one per cycle
// while the receiver takes them. A stalled receiver simply holds the
// current digest word; the core waits. After the final word the initial
// value is reloaded and the next message may start.
// The config channel (i_cfg_valid / o_cfg_ready) writes the variant bit and
// restarts the message. Synchronous active-low reset selects SHA-256 and
// clears all counters.
module sha256_hash_core_top
    import sha_pkg::*;
#(
    parameter int ROUNDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_variant
);

    logic r_variant;
    t_cmd cmd;
    t_status status;
    logic [63:0] bit_len;
    t_word rd_word;
    logic [2:0] rd_index;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_variant <= 1'b0;
        else if (i_cfg_valid) r_variant <= i_cfg_variant;
    end

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_data_word, .i_valid_bytes,
        .i_is_last, .i_cfg_valid, .i_variant(r_variant), .i_status(status),
        .i_bit_len(bit_len), .i_rd_word(rd_word), .o_rd_index(rd_index), .o_cmd(cmd),
        .o_out_valid, .i_out_ready, .o_digest_word, .o_word_index, .o_last_word
    );

    sha_datapath #(.ROUNDS(ROUNDS)) u_dp (
        .i_clk, .i_rst_n, .i_variant(i_cfg_valid ? i_cfg_variant : r_variant),
        .i_cmd(cmd), .i_rd_index(rd_index), .o_rd_word(rd_word),
        .o_bit_len(bit_len), .o_status(status)
    );

endmodule
